FILE: hdl/acspi_pkg.sv
// Shared types and constants for the AC SPI frame checker.
// No dependencies; imported by acspi_track and ac_spi_frame_checker_unit.
`default_nettype none

package acspi_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned STAT_W = 3;

  // Byte position saturates here; bytes at this index or later are ignored
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Signature bytes
  localparam logic [BYTE_W-1:0] SIG0_MASK  = 8'hfe;
  localparam logic [BYTE_W-1:0] SIG0_VALUE = 8'h6c;
  localparam logic [BYTE_W-1:0] SIG1_VALUE = 8'h80;
  localparam logic [BYTE_W-1:0] SIG2_VALUE = 8'h04;
  localparam logic [BYTE_W-1:0] LOW_MASK   = 8'hff;

  // Signature byte positions
  localparam logic [POS_W-1:0] SIG0_POS = 6'd0;
  localparam logic [POS_W-1:0] SIG1_POS = 6'd1;
  localparam logic [POS_W-1:0] SIG2_POS = 6'd2;

  // Status codes, lowest nonzero code has priority
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEN   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SIG   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SHORT = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_LONG  = 3'd4;

  // Frame report handed from the tracker to the output register
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              is_long;
    logic [SUM_W-1:0]  computed_sum;
  } acspi_result_t;

endpackage

`default_nettype wire

FILE: hdl/ac_spi_frame_checker_unit.sv
// AC SPI frame checker, top level: input register, tracker, result register.
// Depends on acspi_pkg and acspi_track.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one received byte per transfer,
//   rx_byte in frame order, with frame_end set on the last byte of the frame.
//   Output channel (out_valid/out_stall) carries one frame report per frame:
//   status, is_long and computed_sum (sum latched at the short checksum).
//   Bytes other than the last produce no output transfer.
// Pipeline and throughput:
//   A byte is registered on acceptance and checked from the input register;
//   a last byte loads its report into the result register as it leaves.
//   One byte per cycle is sustained unless a last byte waits on a held
//   report; the running sum's add and compare sit between these registers.
// Reset:
//   rst (synchronous) clears position, sum, fault flags and both pipeline
//   valid bits; no report is pending afterwards.
// Stall:
//   While out_stall holds a report, ordinary bytes keep flowing; a last byte
//   waits in the input register, and in_stall rises until the slot frees.
`default_nettype none

module ac_spi_frame_checker_unit #(
  parameter int unsigned SHORT_LEN = 20,
  parameter int unsigned LONG_LEN  = 33
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [acspi_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic                          frame_end,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [acspi_pkg::STAT_W-1:0]  status,
  output      logic                          is_long,
  output      logic [acspi_pkg::SUM_W-1:0]   computed_sum
);
  import acspi_pkg::*;

  logic              hold_valid;
  logic [BYTE_W-1:0] hold_byte;
  logic              hold_end;
  logic              out_free;
  logic              step;
  acspi_result_t     result;
  acspi_result_t     report;

  assign out_free = !out_valid || !out_stall;
  assign step     = hold_valid && (!hold_end || out_free);
  assign in_stall = hold_valid && !step;

  acspi_track #(
    .SHORT_LEN (SHORT_LEN),
    .LONG_LEN  (LONG_LEN)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (hold_byte),
    .frame_end (hold_end),
    .result    (result)
  );

  // Input register: take a transfer whenever the held byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      hold_byte <= rx_byte;
      hold_end  <= frame_end;
    end
  end

  // Result register: load a report on the last byte, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && hold_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && hold_end) begin
      report <= result;
    end
  end

  assign status       = report.status;
  assign is_long      = report.is_long;
  assign computed_sum = report.computed_sum;

endmodule

`default_nettype wire

FILE: hdl/acspi_track.sv
// Per-frame state tracker: byte position, running sum, fault flags.
// Depends on acspi_pkg; instantiated by ac_spi_frame_checker_unit.
`default_nettype none

module acspi_track #(
  parameter int unsigned SHORT_LEN = 20,
  parameter int unsigned LONG_LEN  = 33
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic [acspi_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic                          frame_end,
  output acspi_pkg::acspi_result_t           result
);
  import acspi_pkg::*;

  localparam logic [POS_W-1:0] SHORT_HI_POS = POS_W'(SHORT_LEN - 2);
  localparam logic [POS_W-1:0] SHORT_LO_POS = POS_W'(SHORT_LEN - 1);
  localparam logic [POS_W-1:0] LONG_CK_POS  = POS_W'(LONG_LEN - 1);

  logic [POS_W-1:0]  byte_position;
  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W-1:0]  short_sum_latched;
  logic              signature_bad;
  logic              short_sum_bad;
  logic              long_sum_bad;
  logic [BYTE_W-1:0] high_check_byte;

  logic [POS_W-1:0]  byte_position_next;
  logic [SUM_W-1:0]  running_sum_next;
  logic [SUM_W-1:0]  short_sum_latched_next;
  logic              signature_bad_next;
  logic              short_sum_bad_next;
  logic              long_sum_bad_next;
  logic [BYTE_W-1:0] high_check_byte_next;

  logic              in_range;
  logic [SUM_W-1:0]  sum_plus;
  logic [SUM_W-1:0]  rx_check;

  assign in_range = (byte_position != POS_MAX);
  assign sum_plus = running_sum + SUM_W'(rx_byte);
  assign rx_check = {high_check_byte, rx_byte};

  // Update position, sum and fault flags for one byte
  always_comb begin
    byte_position_next     = byte_position;
    running_sum_next       = running_sum;
    short_sum_latched_next = short_sum_latched;
    signature_bad_next     = signature_bad;
    short_sum_bad_next     = short_sum_bad;
    long_sum_bad_next      = long_sum_bad;
    high_check_byte_next   = high_check_byte;

    if (in_range) begin
      if (byte_position == SIG0_POS && (rx_byte & SIG0_MASK) != SIG0_VALUE) begin
        signature_bad_next = 1'b1;
      end
      if (byte_position == SIG1_POS && rx_byte != SIG1_VALUE) begin
        signature_bad_next = 1'b1;
      end
      if (byte_position == SIG2_POS && rx_byte != SIG2_VALUE) begin
        signature_bad_next = 1'b1;
      end

      if (byte_position == SHORT_HI_POS) begin
        short_sum_latched_next = running_sum;
        high_check_byte_next   = rx_byte;
        running_sum_next       = sum_plus;
      end else if (byte_position == SHORT_LO_POS) begin
        if (rx_check != short_sum_latched) begin
          short_sum_bad_next = 1'b1;
        end
        running_sum_next = sum_plus;
      end else if (byte_position == LONG_CK_POS) begin
        if ((running_sum[BYTE_W-1:0] & LOW_MASK) != rx_byte) begin
          long_sum_bad_next = 1'b1;
        end
      end else begin
        running_sum_next = sum_plus;
      end
      byte_position_next = byte_position + 1'b1;
    end
  end

  // Build the frame report from the updated flags
  always_comb begin
    result.is_long      = 1'b0;
    result.computed_sum = short_sum_latched_next;
    if (!in_range) begin
      result.status = ST_BAD_LEN;
    end else if (byte_position == LONG_CK_POS) begin
      result.is_long = 1'b1;
      result.status  = signature_bad_next ? ST_BAD_SIG :
                       short_sum_bad_next ? ST_BAD_SHORT :
                       long_sum_bad_next  ? ST_BAD_LONG : ST_OK;
    end else if (byte_position == SHORT_LO_POS) begin
      result.status = signature_bad_next ? ST_BAD_SIG :
                      short_sum_bad_next ? ST_BAD_SHORT : ST_OK;
    end else begin
      result.status = ST_BAD_LEN;
    end
  end

  // Hold state; advance on each byte, clear after the last one
  always_ff @(posedge clk) begin
    if (rst || (step && frame_end)) begin
      byte_position     <= '0;
      running_sum       <= '0;
      short_sum_latched <= '0;
      signature_bad     <= 1'b0;
      short_sum_bad     <= 1'b0;
      long_sum_bad      <= 1'b0;
      high_check_byte   <= '0;
    end else if (step) begin
      byte_position     <= byte_position_next;
      running_sum       <= running_sum_next;
      short_sum_latched <= short_sum_latched_next;
      signature_bad     <= signature_bad_next;
      short_sum_bad     <= short_sum_bad_next;
      long_sum_bad      <= long_sum_bad_next;
      high_check_byte   <= high_check_byte_next;
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_ac_spi_frame_checker_unit.sv
// Self-checking testbench for ac_spi_frame_checker_unit: frames of received bytes in, reports out.
// Depends on acspi_pkg and the checker RTL; a frame scoreboard class predicts every report.
`timescale 1ns / 100ps

module tb_ac_spi_frame_checker_unit;
  import acspi_pkg::*;

  localparam int SHORT_LEN  = 20;
  localparam int LONG_LEN   = 33;
  localparam int RAND_ITEMS = 1700;
  localparam int BUF_LEN    = 96;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   rx_byte = '0;
  logic                frame_end = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic                is_long;
  logic [SUM_W-1:0]    computed_sum;

  ac_spi_frame_checker_unit #(
    .SHORT_LEN(SHORT_LEN),
    .LONG_LEN (LONG_LEN)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .frame_end   (frame_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .is_long     (is_long),
    .computed_sum(computed_sum)
  );

  // Frame predictor plus queue of expected reports
  class frame_scoreboard;
    logic [POS_W-1:0]  pos;
    logic [SUM_W-1:0]  run_sum;
    logic [SUM_W-1:0]  short_sum;
    logic [BYTE_W-1:0] sum_hi;
    bit                sig_bad;
    bit                short_bad;
    bit                long_bad;
    acspi_result_t     report_q[$];
    int                n_bad;

    function new();
      clear_frame();
      n_bad = 0;
    endfunction

    function void clear_frame();
      pos       = '0;
      run_sum   = '0;
      short_sum = '0;
      sum_hi    = '0;
      sig_bad   = 1'b0;
      short_bad = 1'b0;
      long_bad  = 1'b0;
    endfunction

    // Advance the frame state by one accepted byte; queue a report on the last one
    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      logic [POS_W-1:0] p;
      acspi_result_t    rep;
      p = pos;
      if (p != POS_MAX) begin
        if (p == SIG0_POS && (b & SIG0_MASK) != SIG0_VALUE) sig_bad = 1'b1;
        if (p == SIG1_POS && b != SIG1_VALUE) sig_bad = 1'b1;
        if (p == SIG2_POS && b != SIG2_VALUE) sig_bad = 1'b1;
        if (int'(p) == SHORT_LEN - 2) begin
          short_sum = run_sum;
          sum_hi    = b;
          run_sum   = run_sum + SUM_W'(b);
        end else if (int'(p) == SHORT_LEN - 1) begin
          if ({sum_hi, b} != short_sum) short_bad = 1'b1;
          run_sum = run_sum + SUM_W'(b);
        end else if (int'(p) == LONG_LEN - 1) begin
          if ((run_sum[BYTE_W-1:0] & LOW_MASK) != b) long_bad = 1'b1;
        end else begin
          run_sum = run_sum + SUM_W'(b);
        end
        pos = p + 1'b1;
      end
      if (last) begin
        rep.is_long = 1'b0;
        if (p == POS_MAX) begin
          rep.status = ST_BAD_LEN;
        end else if (int'(p) + 1 == LONG_LEN) begin
          rep.is_long = 1'b1;
          rep.status  = sig_bad ? ST_BAD_SIG : short_bad ? ST_BAD_SHORT :
                        long_bad ? ST_BAD_LONG : ST_OK;
        end else if (int'(p) + 1 == SHORT_LEN) begin
          rep.status = sig_bad ? ST_BAD_SIG : short_bad ? ST_BAD_SHORT : ST_OK;
        end else begin
          rep.status = ST_BAD_LEN;
        end
        rep.computed_sum = short_sum;
        report_q.push_back(rep);
        clear_frame();
      end
    endfunction

    // Compare one report transfer against the oldest expectation
    function void check_report(logic [STAT_W-1:0] st, logic lg, logic [SUM_W-1:0] sum);
      acspi_result_t exp_rep;
      if (report_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected report: status %0d is_long %0d sum %h", st, lg, sum);
        return;
      end
      exp_rep = report_q.pop_front();
      if (st !== exp_rep.status || lg !== exp_rep.is_long ||
          sum !== exp_rep.computed_sum) begin
        n_bad++;
        if (n_bad <= 10)
          $display("report mismatch: status exp %0d got %0d, is_long exp %0d got %0d, sum exp %h got %h",
                   exp_rep.status, st, exp_rep.is_long, lg, exp_rep.computed_sum, sum);
      end
    endfunction
  endclass

  frame_scoreboard   sb = new();
  logic [BYTE_W-1:0] fbuf [0:BUF_LEN-1];
  int                flen;
  int                burst_left = 0;
  int                items_sent = 0;
  int                hold_req = 0;
  int                hold_left = 0;
  int                stall_mode = 0;
  int                pat_cnt = 0;

  // Clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver stall pattern; a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      pat_cnt++;
      if (pat_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_req != 0) begin
        hold_req  = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (pat_cnt % 3 == 0);
        endcase
      end
    end
  end

  // Report monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_report(status, is_long, computed_sum);
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // Fill the frame buffer with a well-formed short or long frame
  task automatic build_good(bit lg);
    logic [SUM_W-1:0] s;
    s = '0;
    fbuf[0] = SIG0_VALUE | BYTE_W'($urandom_range(0, 1));
    fbuf[1] = SIG1_VALUE;
    fbuf[2] = SIG2_VALUE;
    for (int i = 3; i <= SHORT_LEN - 3; i++) fbuf[i] = rand_byte();
    for (int i = 0; i <= SHORT_LEN - 3; i++) s = s + SUM_W'(fbuf[i]);
    fbuf[SHORT_LEN-2] = s[15:8];
    fbuf[SHORT_LEN-1] = s[7:0];
    flen = SHORT_LEN;
    if (lg) begin
      s = s + SUM_W'(fbuf[SHORT_LEN-2]) + SUM_W'(fbuf[SHORT_LEN-1]);
      for (int i = SHORT_LEN; i <= LONG_LEN - 2; i++) begin
        fbuf[i] = rand_byte();
        s = s + SUM_W'(fbuf[i]);
      end
      fbuf[LONG_LEN-1] = s[7:0];
      flen = LONG_LEN;
    end
  endtask

  // Offer one byte and hold it until the transfer; bursts with random gaps
  task automatic send_byte(logic [BYTE_W-1:0] b, logic last, bit bursty);
    if (bursty && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    rx_byte   <= b;
    frame_end <= last;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b, last);
    items_sent++;
  endtask

  task automatic send_frame(bit bursty);
    for (int i = 0; i < flen; i++) send_byte(fbuf[i], i == flen - 1, bursty);
  endtask

  // Stop offering and hold until every expected report has come back or the wait limit is reached
  task automatic drain_reports();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.report_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin
    int kind;
    int frames;
    int cpos;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single-byte frames at both extremes, a too-short frame, a good short frame
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b1, 1'b0);
    send_byte(SIG0_VALUE | 8'h01, 1'b0, 1'b0);
    send_byte(SIG1_VALUE, 1'b0, 1'b0);
    send_byte(SIG2_VALUE, 1'b1, 1'b0);
    build_good(1'b0);
    send_frame(1'b0);
    drain_reports();

    // Random frames: well-formed, truncated, overlong and random-byte frames
    frames = 0;
    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        build_good(1'b0);
      end else if (kind < 65) begin
        build_good(1'b1);
      end else if (kind < 78) begin
        build_good(1'b1);
        flen = $urandom_range(1, 40);
        for (int i = LONG_LEN; i < flen; i++) fbuf[i] = rand_byte();
      end else if (kind < 88) begin
        flen = $urandom_range(1, 40);
        for (int i = 0; i < flen; i++) fbuf[i] = rand_byte();
      end else if (kind < 94) begin
        flen = $urandom_range(62, 72);
        for (int i = 0; i < flen; i++) fbuf[i] = rand_byte();
        if ($urandom_range(0, 1) == 1) build_good(1'b1);
      end else begin
        build_good(1'b1);
        flen = ($urandom_range(0, 1) == 1) ? SHORT_LEN + 1 : LONG_LEN - 1;
        if ($urandom_range(0, 1) == 1) flen = ($urandom_range(0, 1) == 1) ? SHORT_LEN - 1 : LONG_LEN + 1;
        fbuf[LONG_LEN] = rand_byte();
      end

      // Corrupt a byte in about a third of the frames
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: cpos = $urandom_range(0, 2);
          1: cpos = $urandom_range(SHORT_LEN - 2, SHORT_LEN - 1);
          2: cpos = LONG_LEN - 1;
          default: cpos = $urandom_range(0, LONG_LEN - 1);
        endcase
        if (cpos < flen) fbuf[cpos] = fbuf[cpos] ^ BYTE_W'($urandom_range(1, 255));
      end

      if (frames == 10) hold_req = 1;
      send_frame(1'b1);
      frames++;
      if (frames == 30 || $urandom_range(0, 19) == 0) drain_reports();
    end

    // Wind down
    drain_reports();
    repeat (10) @(posedge clk);
    sb.n_bad += sb.report_q.size();
    if (sb.n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/acspi_pkg.sv
hdl/acspi_track.sv
hdl/ac_spi_frame_checker_unit.sv
test/tb_ac_spi_frame_checker_unit.sv
